>>> rtl/core/mfmp_pkg.sv
// Shared constants and types for the modular Fibonacci matrix-power block.
// No dependencies.
package mfmp_pkg;
   localparam int INDEX_BITS = 63;
   localparam int CNT_W      = $clog2(INDEX_BITS);
   localparam int MOD_W      = 27;
   localparam int BIT_W      = $clog2(MOD_W);
   localparam logic [MOD_W-1:0] MODULUS = MOD_W'(100000007);

   typedef logic [MOD_W-1:0] elem_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_BASE,
      ST_OUT
   } state_type;
endpackage

>>> rtl/core/mfmp_ifs.sv
// Valid/ready channel interfaces for the request and response beats.
// Depends on mfmp_pkg.
interface mfmp_req_if import mfmp_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [INDEX_BITS-1:0] index;
   modport source (output valid, output index, input ready);
   modport sink   (input valid, input index, output ready);
endinterface

interface mfmp_rsp_if import mfmp_pkg::*; ();
   logic     valid;
   logic     ready;
   elem_type fib_value;
   modport source (output valid, output fib_value, input ready);
   modport sink   (input valid, input fib_value, output ready);
endinterface

>>> rtl/core/modular_fibonacci_matrix_power.sv
// Fibonacci(n+1) mod 100000007 by 2x2 matrix square-and-multiply.
// Depends on mfmp_pkg and the channel interfaces in mfmp_ifs.sv.
//
// One request beat carries an index n; one response beat returns F(n+1) mod
// 100000007 (n = 0 gives 1). The exponent is scanned MSB first over
// INDEX_BITS bits. Each bit squares the accumulator matrix with eight modular
// products on a single bit-serial multiplier (one multiplier bit per cycle),
// then, for a set bit, multiplies by [[1,1],[1,0]] using adds only in ST_BASE.
// One item is in flight at a time; the next request is taken once the result
// sits in the response register, even while that beat waits for the sink.
module modular_fibonacci_matrix_power import mfmp_pkg::*; (
   input logic        clock,
   input logic        reset,
   mfmp_req_if.sink   req_ch,
   mfmp_rsp_if.source rsp_ch
);
   state_type             state_ff, state_in;
   logic [INDEX_BITS-1:0] exp_ff;
   logic [CNT_W-1:0]      cnt_ff;
   logic [BIT_W-1:0]      bcnt_ff;
   logic [2:0]            sel_ff;
   elem_type              a11_ff, a12_ff, a21_ff, a22_ff;
   elem_type              n11_ff, n12_ff, n21_ff;
   elem_type              prod_ff, sum_ff;
   logic                  rsp_valid_ff;
   elem_type              rsp_value_ff;

   elem_type        opx, opy, prod_nx, sum_nx, b11, b12;
   logic [MOD_W:0]  dbl, dblr, add;
   logic            last_bit, last_prod, advance, load_out, accept;

   assign accept          = req_ch.valid && req_ch.ready;
   assign req_ch.ready    = (state_ff == ST_IDLE);
   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.fib_value = rsp_value_ff;

   // operand pair for entry sel[2:1], term sel[0]
   always_comb begin
      case (sel_ff)
         3'd0: begin opx = a11_ff; opy = a11_ff; end
         3'd1: begin opx = a12_ff; opy = a21_ff; end
         3'd2: begin opx = a11_ff; opy = a12_ff; end
         3'd3: begin opx = a12_ff; opy = a22_ff; end
         3'd4: begin opx = a21_ff; opy = a11_ff; end
         3'd5: begin opx = a22_ff; opy = a21_ff; end
         3'd6: begin opx = a21_ff; opy = a12_ff; end
         default: begin opx = a22_ff; opy = a22_ff; end
      endcase
   end

   // one MSB-first shift-add step: r = 2r + bit*y mod M
   always_comb begin
      dbl  = {prod_ff, 1'b0};
      dblr = (dbl >= {1'b0, MODULUS}) ? dbl - {1'b0, MODULUS} : dbl;
      add  = dblr + ((opx[BIT_W'(MOD_W-1) - bcnt_ff]) ? {1'b0, opy} : '0);
      prod_nx = (add >= {1'b0, MODULUS}) ? MOD_W'(add - {1'b0, MODULUS})
                                         : add[MOD_W-1:0];
      add  = {1'b0, sum_ff} + {1'b0, prod_nx};
      sum_nx = (!sel_ff[0]) ? prod_nx
             : ((add >= {1'b0, MODULUS}) ? MOD_W'(add - {1'b0, MODULUS})
                                         : add[MOD_W-1:0]);
      add  = {1'b0, a11_ff} + {1'b0, a21_ff};
      b11  = (add >= {1'b0, MODULUS}) ? MOD_W'(add - {1'b0, MODULUS}) : add[MOD_W-1:0];
      add  = {1'b0, a12_ff} + {1'b0, a22_ff};
      b12  = (add >= {1'b0, MODULUS}) ? MOD_W'(add - {1'b0, MODULUS}) : add[MOD_W-1:0];
   end

   always_comb begin
      state_in  = state_ff;
      last_bit  = (bcnt_ff == BIT_W'(MOD_W-1));
      last_prod = last_bit && (sel_ff == 3'd7);
      advance   = 1'b0;
      load_out  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_MUL;
         end
         ST_MUL: begin
            if (last_prod) begin
               if (exp_ff[INDEX_BITS-1]) begin
                  state_in = ST_BASE;
               end else begin
                  advance  = 1'b1;
                  state_in = (cnt_ff == '0) ? ST_OUT : ST_MUL;
               end
            end
         end
         ST_BASE: begin
            advance  = 1'b1;
            state_in = (cnt_ff == '0) ? ST_OUT : ST_MUL;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               load_out = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) rsp_value_ff <= a11_ff;
      if (accept) begin
         exp_ff  <= req_ch.index;
         cnt_ff  <= CNT_W'(INDEX_BITS-1);
         bcnt_ff <= '0;
         sel_ff  <= '0;
         prod_ff <= '0;
         a11_ff  <= MOD_W'(1);
         a12_ff  <= '0;
         a21_ff  <= '0;
         a22_ff  <= MOD_W'(1);
      end else if (state_ff == ST_MUL) begin
         if (last_bit) begin
            bcnt_ff <= '0;
            prod_ff <= '0;
            sel_ff  <= sel_ff + 3'd1;
            sum_ff  <= sum_nx;
            case (sel_ff)
               3'd1: n11_ff <= sum_nx;
               3'd3: n12_ff <= sum_nx;
               3'd5: n21_ff <= sum_nx;
               3'd7: begin
                  a11_ff <= n11_ff;
                  a12_ff <= n12_ff;
                  a21_ff <= n21_ff;
                  a22_ff <= sum_nx;
               end
               default: ;
            endcase
         end else begin
            bcnt_ff <= bcnt_ff + BIT_W'(1);
            prod_ff <= prod_nx;
         end
      end else if (state_ff == ST_BASE) begin
         a11_ff <= b11;
         a12_ff <= b12;
         a21_ff <= a11_ff;
         a22_ff <= a12_ff;
      end
      if (advance) begin
         exp_ff <= {exp_ff[INDEX_BITS-2:0], 1'b0};
         cnt_ff <= cnt_ff - CNT_W'(1);
      end
   end

`ifndef SYNTH
   a_rsp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_value_ff < MODULUS))
      else $error("response out of range");
   a_prod_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL) |-> (prod_ff < MODULUS))
      else $error("partial product not reduced");
   a_start: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_MUL) && (cnt_ff == CNT_W'(INDEX_BITS-1)))
      else $error("accepted beat did not start");
`endif
endmodule
